@@ rtl/skd2r_pkg.sv @@
// ----------------------------------------------------------------------------
// skd2r_pkg
// Types, constants and state codes for the sliding-window D2R statistic.
// ----------------------------------------------------------------------------
package skd2r_pkg;

    localparam int WINDOW_MAX = 4096;
    localparam int K_MAX      = 8;
    localparam int PROB_BITS  = 16;
    localparam int RING_AW    = $clog2(WINDOW_MAX);
    localparam int CODE_W     = 2 * K_MAX;
    localparam int COUNT_W    = 13;
    localparam int PAIR_W     = 24;
    localparam int SUM_W      = 64;
    localparam int WLEN_W     = 13;
    localparam int KLEN_W     = 4;

    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
    localparam logic [PAIR_W-1:0]  PAIR_TOP  = '1;

    typedef struct packed {
        logic [1:0] base;
        logic       seq_start;
    } in_t;

    typedef struct packed {
        logic signed [31:0] d2r;
        logic [31:0]        window_pos;
    } out_t;

    typedef enum logic [2:0] {
        CFG_WINDOW_LEN  = 3'd0,
        CFG_KMER_LEN    = 3'd1,
        CFG_PROB_A      = 3'd2,
        CFG_PROB_C      = 3'd3,
        CFG_PROB_G      = 3'd4,
        CFG_PROB_T      = 3'd5,
        CFG_PAIR_RECIP  = 3'd6,
        CFG_COUNT_RATIO = 3'd7
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RING_RD,
        ST_RING_UPD,
        ST_DROP_RD,
        ST_DROP_UPD,
        ST_TAKE_RD,
        ST_TAKE_UPD,
        ST_SQ_INIT,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQ_SQ,
        ST_SQ_APPLY,
        ST_FIN,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_OUT
    } state_t;

endpackage

@@ rtl/sliding_kmer_d2r_statistic.sv @@
// ----------------------------------------------------------------------------
// sliding_kmer_d2r_statistic
// Sliding-window D2R statistic over a stream of DNA bases, one base a beat.
// ----------------------------------------------------------------------------
// One base is taken at a time and the input stays not ready until it has been
// worked through; a single 32 by 32 multiplier under a small sequencer does
// all the multiplications. Once the window is full, the leaving and the
// entering word of a base may each need a word probability; each costs a
// set-up step, a multiply and an accumulate step per base of the word beyond
// the first, then its square and the update of the sum. Before the window is
// full, the result arithmetic (states ST_M0 to ST_M4 and ST_OUT) is left out.
// After reset, and after every beat that carries the start flag, the count
// table is cleared one entry a cycle over all 65536 entries; configuration
// writes are taken as ever during that pass. A result beat may wait at the
// output while the next base is already being worked on.
module sliding_kmer_d2r_statistic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  skd2r_pkg::in_t     s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output skd2r_pkg::out_t    m_data
);
    import skd2r_pkg::*;

    state_t state_reg, state_next;

    logic [WLEN_W-1:0]    window_len_reg;
    logic [KLEN_W-1:0]    kmer_len_reg;
    logic [PROB_BITS-1:0] prob_reg [4];
    logic [47:0]          pair_recip_reg;
    logic [31:0]          count_ratio_reg;

    logic [COUNT_W-1:0] cnt_mem [1 << CODE_W];
    logic [1:0]         ring_mem [WINDOW_MAX];

    logic [COUNT_W-1:0] cnt_rdata_reg;
    logic [1:0]         ring_rdata_reg;
    logic [CODE_W-1:0]  clr_addr_reg;
    logic               pend_reg;
    logic [1:0]         base_reg;

    logic [PAIR_W-1:0]  pair_sum_reg;
    logic [SUM_W-1:0]   expect_sum_reg;
    logic [RING_AW-1:0] ring_ptr_reg;
    logic [31:0]        bases_seen_reg;
    logic [CODE_W-1:0]  tail_code_reg, head_code_reg;
    logic               enter_reg;
    logic               sq_take_reg;
    logic [KLEN_W-1:0]  sq_i_reg;
    logic [31:0]        acc_reg;
    logic [63:0]        prod_reg;
    logic [47:0]        y_reg;
    logic [54:0]        a_reg;
    logic [63:0]        t_reg;
    logic [32:0]        b_reg;
    logic               m_valid_reg;
    out_t               m_data_reg;

    logic [WLEN_W-1:0]  w_c;
    logic [KLEN_W-1:0]  k0_c, k_c;
    logic [WLEN_W-1:0]  n_c;
    logic [CODE_W-1:0]  mask_c;
    logic [CODE_W-1:0]  head_new, tail_new, sq_code;
    logic               enter_c, leave_c;
    logic [31:0]        mul_a, mul_b;
    logic               cnt_we, cnt_re, ring_we, ring_re;
    logic [CODE_W-1:0]  cnt_waddr, cnt_raddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [RING_AW-1:0] ring_raddr;
    logic [1:0]         digit_top, digit_cur;
    logic [4:0]         sh_top, sh_cur;
    logic [24:0]        pair_add;
    logic [24:0]        pair_dec;
    logic [64:0]        exp_add;
    logic [63:0]        t_sum;
    logic [55:0]        d_pos;
    logic [33:0]        d_neg;
    logic [31:0]        d2r_c;
    logic               accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        if (window_len_reg < WLEN_W'(2)) begin
            w_c = WLEN_W'(2);
        end else if (window_len_reg > WLEN_W'(WINDOW_MAX)) begin
            w_c = WLEN_W'(WINDOW_MAX);
        end else begin
            w_c = window_len_reg;
        end
        if (kmer_len_reg < KLEN_W'(1)) begin
            k0_c = KLEN_W'(1);
        end else if (kmer_len_reg > KLEN_W'(K_MAX)) begin
            k0_c = KLEN_W'(K_MAX);
        end else begin
            k0_c = kmer_len_reg;
        end
        if (WLEN_W'(k0_c) >= w_c) begin
            k_c = KLEN_W'(w_c - WLEN_W'(1));
        end else begin
            k_c = k0_c;
        end
        n_c    = w_c - WLEN_W'(k_c) + WLEN_W'(1);
        mask_c = {CODE_W{1'b1}} >> (5'(CODE_W) - {k_c, 1'b0});
    end

    always_comb begin
        head_new = head_code_reg;
        if (bases_seen_reg >= 32'(n_c)) begin
            head_new = ((head_code_reg << 2) | CODE_W'(ring_rdata_reg)) & mask_c;
        end
        tail_new = ((tail_code_reg << 2) | CODE_W'(base_reg)) & mask_c;
        enter_c  = ({1'b0, bases_seen_reg} + 33'd1 >= 33'(k_c)) || (bases_seen_reg == '1);
        leave_c  = bases_seen_reg >= 32'(w_c);
        sq_code  = sq_take_reg ? tail_code_reg : head_code_reg;
        sh_top   = {k_c - KLEN_W'(1), 1'b0};
        sh_cur   = {sq_i_reg - KLEN_W'(1), 1'b0};
        digit_top = 2'(sq_code >> sh_top);
        digit_cur = 2'(sq_code >> sh_cur);
        pair_add = {1'b0, pair_sum_reg} + {11'b0, cnt_rdata_reg, 1'b0};
        pair_dec = {11'b0, cnt_rdata_reg - COUNT_W'(1), 1'b0};
        exp_add  = {1'b0, expect_sum_reg} + {1'b0, prod_reg};
        t_sum    = t_reg + {32'b0, prod_reg[63:32]};
        d_pos    = {1'b0, a_reg} - {23'b0, b_reg};
        d_neg    = {1'b0, b_reg} - 34'(a_reg);
        if ({1'b0, a_reg} >= {23'b0, b_reg}) begin
            d2r_c = (d_pos > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF : d_pos[31:0];
        end else begin
            d2r_c = (d_neg >= 34'h8000_0000) ? 32'h8000_0000 : 32'd0 - d_neg[31:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = s_data.seq_start ? ST_CLEAR : ST_RING_RD;
                end
            end
            ST_CLEAR: begin
                if (clr_addr_reg == '1) begin
                    state_next = pend_reg ? ST_RING_RD : ST_IDLE;
                end
            end
            ST_RING_RD: state_next = ST_RING_UPD;
            ST_RING_UPD: begin
                if (enter_c && leave_c && head_new == tail_new) begin
                    state_next = ST_FIN;
                end else if (leave_c) begin
                    state_next = ST_DROP_RD;
                end else if (enter_c) begin
                    state_next = ST_TAKE_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DROP_RD: state_next = ST_DROP_UPD;
            ST_DROP_UPD: begin
                if (cnt_rdata_reg == COUNT_W'(1)) begin
                    state_next = ST_SQ_INIT;
                end else begin
                    state_next = enter_reg ? ST_TAKE_RD : ST_FIN;
                end
            end
            ST_TAKE_RD: state_next = ST_TAKE_UPD;
            ST_TAKE_UPD: begin
                if (cnt_rdata_reg == '0) begin
                    state_next = ST_SQ_INIT;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SQ_INIT: state_next = (k_c == KLEN_W'(1)) ? ST_SQ_SQ : ST_SQ_MUL;
            ST_SQ_MUL:  state_next = ST_SQ_ACC;
            ST_SQ_ACC:  state_next = (sq_i_reg == KLEN_W'(1)) ? ST_SQ_SQ : ST_SQ_MUL;
            ST_SQ_SQ:   state_next = ST_SQ_APPLY;
            ST_SQ_APPLY: begin
                state_next = (!sq_take_reg && enter_reg) ? ST_TAKE_RD : ST_FIN;
            end
            ST_FIN: begin
                if (bases_seen_reg == '1 || bases_seen_reg + 32'd1 >= 32'(w_c)) begin
                    state_next = ST_M0;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_M0: state_next = ST_M1;
            ST_M1: state_next = ST_M2;
            ST_M2: state_next = ST_M3;
            ST_M3: state_next = ST_M4;
            ST_M4: state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        cnt_we    = 1'b0;
        cnt_waddr = clr_addr_reg;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = head_code_reg;
        ring_we   = 1'b0;
        ring_re   = 1'b0;
        ring_raddr = ring_ptr_reg - RING_AW'(n_c);
        mul_a     = acc_reg;
        mul_b     = acc_reg;
        unique case (state_reg)
            ST_IDLE:    s_ready = 1'b1;
            ST_CLEAR:   cnt_we = 1'b1;
            ST_RING_RD: ring_re = 1'b1;
            ST_RING_UPD: ring_we = 1'b1;
            ST_DROP_RD: cnt_re = 1'b1;
            ST_DROP_UPD: begin
                if (cnt_rdata_reg != '0) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = head_code_reg;
                    cnt_wdata = cnt_rdata_reg - COUNT_W'(1);
                end
            end
            ST_TAKE_RD: begin
                cnt_re    = 1'b1;
                cnt_raddr = tail_code_reg;
            end
            ST_TAKE_UPD: begin
                if (cnt_rdata_reg != COUNT_TOP) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = tail_code_reg;
                    cnt_wdata = cnt_rdata_reg + COUNT_W'(1);
                end
            end
            ST_SQ_MUL: begin
                mul_a = acc_reg;
                mul_b = 32'(prob_reg[digit_cur]);
            end
            ST_M0: begin
                mul_a = 32'(pair_sum_reg);
                mul_b = 32'(pair_recip_reg[23:0]);
            end
            ST_M1: begin
                mul_a = 32'(pair_sum_reg);
                mul_b = 32'(pair_recip_reg[47:24]);
            end
            ST_M2: begin
                mul_a = count_ratio_reg;
                mul_b = expect_sum_reg[63:32];
            end
            ST_M3: begin
                mul_a = count_ratio_reg;
                mul_b = expect_sum_reg[31:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
        end
        if (ring_we) begin
            ring_mem[ring_ptr_reg] <= base_reg;
        end
        if (ring_re) begin
            ring_rdata_reg <= ring_mem[ring_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (accept) begin
            base_reg <= s_data.base;
        end
        if (state_reg == ST_RING_UPD) begin
            enter_reg <= enter_c;
        end
        unique case (state_reg)
            ST_DROP_UPD: sq_take_reg <= 1'b0;
            ST_TAKE_UPD: sq_take_reg <= 1'b1;
            default: begin
            end
        endcase
        if (state_reg == ST_SQ_INIT) begin
            acc_reg  <= 32'(prob_reg[digit_top]) << (32 - PROB_BITS);
            sq_i_reg <= k_c - KLEN_W'(1);
        end else if (state_reg == ST_SQ_ACC) begin
            acc_reg  <= 32'((prod_reg + (64'd1 << (PROB_BITS - 1))) >> PROB_BITS);
            sq_i_reg <= sq_i_reg - KLEN_W'(1);
        end
        if (state_reg == ST_M1) begin
            y_reg <= prod_reg[47:0];
        end
        if (state_reg == ST_M2) begin
            a_reg <= {1'b0, prod_reg[47:0], 6'b0} + 55'((49'(y_reg) + 49'h2_0000) >> 18);
        end
        if (state_reg == ST_M3) begin
            t_reg <= prod_reg;
        end
        if (state_reg == ST_M4) begin
            b_reg <= 33'(t_sum >> 33) + 33'(t_sum[32]);
        end
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_data_reg.d2r        <= d2r_c;
            m_data_reg.window_pos <= bases_seen_reg - 32'(w_c);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            pend_reg        <= 1'b0;
            window_len_reg  <= WLEN_W'(1000);
            kmer_len_reg    <= KLEN_W'(7);
            prob_reg[0]     <= PROB_BITS'(16384);
            prob_reg[1]     <= PROB_BITS'(16384);
            prob_reg[2]     <= PROB_BITS'(16384);
            prob_reg[3]     <= PROB_BITS'(16384);
            pair_recip_reg  <= '0;
            count_ratio_reg <= 32'h8000_0000;
            pair_sum_reg    <= '0;
            expect_sum_reg  <= '0;
            ring_ptr_reg    <= '0;
            bases_seen_reg  <= '0;
            tail_code_reg   <= '0;
            head_code_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_WINDOW_LEN:  window_len_reg  <= cfg_wdata[WLEN_W-1:0];
                    CFG_KMER_LEN:    kmer_len_reg    <= cfg_wdata[KLEN_W-1:0];
                    CFG_PROB_A:      prob_reg[0]     <= cfg_wdata[PROB_BITS-1:0];
                    CFG_PROB_C:      prob_reg[1]     <= cfg_wdata[PROB_BITS-1:0];
                    CFG_PROB_G:      prob_reg[2]     <= cfg_wdata[PROB_BITS-1:0];
                    CFG_PROB_T:      prob_reg[3]     <= cfg_wdata[PROB_BITS-1:0];
                    CFG_PAIR_RECIP:  pair_recip_reg  <= cfg_wdata;
                    CFG_COUNT_RATIO: count_ratio_reg <= cfg_wdata[31:0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + CODE_W'(1);
            end
            if (accept) begin
                pend_reg <= 1'b1;
                if (s_data.seq_start) begin
                    pair_sum_reg   <= '0;
                    expect_sum_reg <= '0;
                    bases_seen_reg <= '0;
                    tail_code_reg  <= '0;
                    head_code_reg  <= '0;
                end
            end
            unique case (state_reg)
                ST_RING_UPD: begin
                    head_code_reg <= head_new;
                    tail_code_reg <= tail_new;
                    ring_ptr_reg  <= ring_ptr_reg + RING_AW'(1);
                end
                ST_DROP_UPD: begin
                    if (cnt_rdata_reg != '0) begin
                        pair_sum_reg <= ({1'b0, pair_sum_reg} >= pair_dec)
                                        ? 24'({1'b0, pair_sum_reg} - pair_dec) : '0;
                    end
                end
                ST_TAKE_UPD: begin
                    if (cnt_rdata_reg != COUNT_TOP) begin
                        pair_sum_reg <= (pair_add > {1'b0, PAIR_TOP}) ? PAIR_TOP
                                        : pair_add[PAIR_W-1:0];
                    end
                end
                ST_SQ_APPLY: begin
                    if (sq_take_reg) begin
                        expect_sum_reg <= exp_add[64] ? '1 : exp_add[63:0];
                    end else begin
                        expect_sum_reg <= (expect_sum_reg >= prod_reg)
                                          ? expect_sum_reg - prod_reg : '0;
                    end
                end
                ST_FIN: begin
                    pend_reg <= 1'b0;
                    if (bases_seen_reg != '1) begin
                        bases_seen_reg <= bases_seen_reg + 32'd1;
                    end
                end
                default: begin
                end
            endcase
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.seq_start) |=> (state_reg == ST_CLEAR))
        else $error("start beat did not begin a table clear");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input ready while a base is being worked on");

    a_result_window_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (bases_seen_reg >= 32'(w_c)))
        else $error("result beat before the window was full");

endmodule
